// ----- src/sun_vector_from_diodes_assert.svh -----
// Assertion macros for the sun vector block.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef SUN_VECTOR_FROM_DIODES_ASSERT_SVH
`define SUN_VECTOR_FROM_DIODES_ASSERT_SVH
`ifndef SYNTHESIS
`define SVC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sun vector check failed");
`define SVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sun vector check failed");
`else
`define SVC_ASSERT_SAME(label, ante, cons)
`define SVC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/svc_pkg.sv -----
// Shared types and constants of the sun vector block.
// No dependencies.
package svc_pkg;
  localparam int AXES      = 3;
  localparam int UNIT_BITS = 16;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;
endpackage

// ----- src/svc_if.sv -----
// Channel interfaces of the sun vector block: sample set in, unit vector out.
// Uses svc_pkg for the output width.
interface svc_in_if #(parameter int SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] plus_x_sample;
  logic [SAMPLE_BITS-1:0] minus_x_sample;
  logic [SAMPLE_BITS-1:0] plus_y_sample;
  logic [SAMPLE_BITS-1:0] minus_y_sample;
  logic [SAMPLE_BITS-1:0] plus_z_sample;
  logic [SAMPLE_BITS-1:0] minus_z_sample;
  modport source (output valid, plus_x_sample, minus_x_sample, plus_y_sample,
                  minus_y_sample, plus_z_sample, minus_z_sample, input ready);
  modport sink (input valid, plus_x_sample, minus_x_sample, plus_y_sample,
                minus_y_sample, plus_z_sample, minus_z_sample, output ready);
endinterface

interface svc_out_if import svc_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [UNIT_BITS-1:0] unit_x;
  logic signed [UNIT_BITS-1:0] unit_y;
  logic signed [UNIT_BITS-1:0] unit_z;
  logic                        vector_valid;
  modport source (output valid, unit_x, unit_y, unit_z, vector_valid, input ready);
  modport sink (input valid, unit_x, unit_y, unit_z, vector_valid, output ready);
endinterface

// ----- src/svc_front.sv -----
// Front stage: picks the stronger diode of each pair and forms the squares.
// Uses svc_pkg.
module svc_front import svc_pkg::*; #(
  parameter int SB = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SB-1:0]     plus_i  [AXES],
  input  logic [SB-1:0]     minus_i [AXES],
  output ctl_t              ctl_r,
  output logic [2*SB+1:0]   s_r,
  output logic [2*SB-1:0]   v2_r    [AXES],
  output logic              neg_r   [AXES]
);
  ctl_t            ctl_nxt;
  logic [2*SB+1:0] s_nxt;
  logic [2*SB-1:0] v2_nxt  [AXES];
  logic            neg_nxt [AXES];
  logic [SB-1:0]   mag     [AXES];

  always_comb begin
    s_nxt = '0;
    for (int i = 0; i < AXES; i++) begin
      // A tie goes to the minus face.
      neg_nxt[i] = !(plus_i[i] > minus_i[i]);
      mag[i]     = neg_nxt[i] ? minus_i[i] : plus_i[i];
      v2_nxt[i]  = (2*SB)'(mag[i]) * (2*SB)'(mag[i]);
      s_nxt      = s_nxt + (2*SB+2)'(v2_nxt[i]);
    end
    ctl_nxt.valid = in_valid;
    ctl_nxt.zero  = (s_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.zero <= ctl_nxt.zero;
      s_r        <= s_nxt;
      v2_r       <= v2_nxt;
      neg_r      <= neg_nxt;
    end
  end
endmodule

// ----- src/svc_cell.sv -----
// One cell of the normalizing chain: decides one quotient bit for all axes.
// Uses svc_pkg. Keeps u^2*S and u*S (u = 2q) so no multiplier is needed.
module svc_cell import svc_pkg::*; #(
  parameter int SB  = 12,
  parameter int F   = 14,
  parameter int BIT = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  ctl_t                  ctl_i,
  input  logic [2*SB+1:0]       s_i,
  input  logic [2*SB-1:0]       v2_i  [AXES],
  input  logic                  neg_i [AXES],
  input  logic [F:0]            q_i   [AXES],
  input  logic [2*SB+2*F+5:0]   a_i   [AXES],
  input  logic [2*SB+2*F+5:0]   b_i   [AXES],
  output ctl_t                  ctl_r,
  output logic [2*SB+1:0]       s_r,
  output logic [2*SB-1:0]       v2_r  [AXES],
  output logic                  neg_r [AXES],
  output logic [F:0]            q_r   [AXES],
  output logic [2*SB+2*F+5:0]   a_r   [AXES],
  output logic [2*SB+2*F+5:0]   b_r   [AXES]
);
  localparam int W = 2*SB + 2*F + 6;

  logic [F:0]   q_nxt [AXES];
  logic [W-1:0] a_nxt [AXES];
  logic [W-1:0] b_nxt [AXES];
  logic [W-1:0] a_c   [AXES];
  logic [W-1:0] b_c   [AXES];
  logic [W-1:0] t_c   [AXES];
  logic [W-1:0] rhs   [AXES];
  logic [W-1:0] s_w;
  logic         take  [AXES];

  always_comb begin
    s_w = W'(s_i);
    for (int i = 0; i < AXES; i++) begin
      // Candidate c = q + 2^BIT, t = 2c - 1; t^2*S = A' - 2B' + S.
      a_c[i]   = a_i[i] + (b_i[i] << (BIT + 2)) + (s_w << (2*BIT + 2));
      b_c[i]   = b_i[i] + (s_w << (BIT + 1));
      t_c[i]   = a_c[i] - (b_c[i] << 1) + s_w;
      rhs[i]   = W'(v2_i[i]) << (2*F + 2);
      // Once q has reached full scale, no lower bit may be added.
      take[i]  = !q_i[i][F] && (t_c[i] <= rhs[i]);
      q_nxt[i] = take[i] ? (q_i[i] | ((F+1)'(1) << BIT)) : q_i[i];
      a_nxt[i] = take[i] ? a_c[i] : a_i[i];
      b_nxt[i] = take[i] ? b_c[i] : b_i[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.zero <= ctl_i.zero;
      s_r        <= s_i;
      v2_r       <= v2_i;
      neg_r      <= neg_i;
      q_r        <= q_nxt;
      a_r        <= a_nxt;
      b_r        <= b_nxt;
    end
  end
endmodule

// ----- src/sun_vector_from_diodes.sv -----
// Top level of the coarse sun sensor vector block.
// Uses svc_pkg, svc_if, svc_front, svc_cell and the assertion macro header.
//
// Usage: one beat on in_ch carries six photodiode samples (+x, -x, +y, -y,
// +z, -z). For each axis the stronger face wins, the minus face on a tie,
// and the three signed axis values are scaled to a unit vector in signed
// fixed point with FRACTION_BITS fraction bits, rounded to nearest. One beat
// leaves on out_ch for every beat taken. When all samples that win are zero
// the components are zero and vector_valid is low.
// Throughput: one beat per cycle while out_ch is not stalled. A beat passes
// through the front stage, a chain of FRACTION_BITS + 1 cells that each decide
// one bit of all three components, and the output register.
// Reset clears every stage valid bit; the pipeline then comes up empty.
// When the receiver stalls with a beat waiting, the whole chain holds and
// in_ch.ready drops, so no beat is lost or repeated.
`include "sun_vector_from_diodes_assert.svh"

module sun_vector_from_diodes import svc_pkg::*; #(
  parameter int SAMPLE_BITS   = 12,
  parameter int FRACTION_BITS = 14
) (
  input  logic clk,
  input  logic rst_n,
  svc_in_if.sink    in_ch,
  svc_out_if.source out_ch
);
  localparam int SB = SAMPLE_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int W  = 2*SB + 2*F + 6;
  localparam int NS = F + 2;

  // Stage k holds the data entering cell k; stage 0 is the front output.
  ctl_t             ctl_s [NS];
  logic [2*SB+1:0]  s_s   [NS];
  logic [2*SB-1:0]  v2_s  [NS][AXES];
  logic             neg_s [NS][AXES];
  logic [F:0]       q_s   [NS][AXES];
  logic [W-1:0]     a_s   [NS][AXES];
  logic [W-1:0]     b_s   [NS][AXES];

  logic [SB-1:0] plus_in  [AXES];
  logic [SB-1:0] minus_in [AXES];
  logic          adv;

  logic                 out_valid_r, out_valid_nxt;
  logic [UNIT_BITS-1:0] unit_r [AXES];
  logic [UNIT_BITS-1:0] unit_nxt [AXES];
  logic                 vvalid_r, vvalid_nxt;
  logic [31:0]          signed_q [AXES];

  // The chain moves as one: it advances whenever the output register is
  // free or being emptied in this cycle.
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign plus_in[0]  = in_ch.plus_x_sample;
  assign minus_in[0] = in_ch.minus_x_sample;
  assign plus_in[1]  = in_ch.plus_y_sample;
  assign minus_in[1] = in_ch.minus_y_sample;
  assign plus_in[2]  = in_ch.plus_z_sample;
  assign minus_in[2] = in_ch.minus_z_sample;

  svc_front #(.SB(SB)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_ch.valid),
    .plus_i   (plus_in),
    .minus_i  (minus_in),
    .ctl_r    (ctl_s[0]),
    .s_r      (s_s[0]),
    .v2_r     (v2_s[0]),
    .neg_r    (neg_s[0])
  );

  // The search starts from q = 0, so both running products start at zero.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      q_s[0][i] = '0;
      a_s[0][i] = '0;
      b_s[0][i] = '0;
    end
  end

  for (genvar k = 0; k <= F; k++) begin : g_cell
    svc_cell #(.SB(SB), .F(F), .BIT(F - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .ctl_i (ctl_s[k]),
      .s_i   (s_s[k]),
      .v2_i  (v2_s[k]),
      .neg_i (neg_s[k]),
      .q_i   (q_s[k]),
      .a_i   (a_s[k]),
      .b_i   (b_s[k]),
      .ctl_r (ctl_s[k+1]),
      .s_r   (s_s[k+1]),
      .v2_r  (v2_s[k+1]),
      .neg_r (neg_s[k+1]),
      .q_r   (q_s[k+1]),
      .a_r   (a_s[k+1]),
      .b_r   (b_s[k+1])
    );
  end

  // Apply the sign and force zeros for a vector of zero length.
  always_comb begin
    out_valid_nxt = adv ? ctl_s[NS-1].valid : out_valid_r;
    vvalid_nxt    = !ctl_s[NS-1].zero;
    for (int i = 0; i < AXES; i++) begin
      signed_q[i] = neg_s[NS-1][i] ? (32'd0 - 32'(q_s[NS-1][i])) : 32'(q_s[NS-1][i]);
      unit_nxt[i] = ctl_s[NS-1].zero ? '0 : signed_q[i][UNIT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unit_r   <= unit_nxt;
      vvalid_r <= vvalid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.unit_x       = unit_r[0];
  assign out_ch.unit_y       = unit_r[1];
  assign out_ch.unit_z       = unit_r[2];
  assign out_ch.vector_valid = vvalid_r;

  // A zero-length vector always leaves as all-zero components.
  `SVC_ASSERT_SAME(a_zero_vec, out_valid_r && !vvalid_r, unit_r[0] == '0 && unit_r[1] == '0 && unit_r[2] == '0)
  // While the chain is held, the last cell keeps its beat.
  `SVC_ASSERT_NEXT(a_hold_last, !adv, $stable(ctl_s[NS-1].valid) && $stable(q_s[NS-1][0]))
  // A held output beat implies the chain did not advance.
  `SVC_ASSERT_SAME(a_stall_ready, out_valid_r && !out_ch.ready, !in_ch.ready)
endmodule
